// ===== hw/rtl/cfl_pkg.sv =====
// shared types, constants and helpers for the compensated four-vector ledger
// no dependencies; imported by every module of the block
package cfl_pkg;

   localparam int unsigned LANES = 4;
   localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int unsigned DATA_W = 64;

   localparam logic [DATA_W-1:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [DATA_W-1:0] POS_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

   // which compensated addition the lanes are working on
   typedef enum logic [4:0] {
      PH_BACC = 5'b00001,
      PH_GACC = 5'b00010,
      PH_BAL0 = 5'b00100,
      PH_BAL1 = 5'b01000,
      PH_BAL2 = 5'b10000
   } cfl_phase_type;

   // the five dependent additions of one compensated addition
   typedef enum logic [4:0] {
      OP_SUM  = 5'b00001,
      OP_DIFF = 5'b00010,
      OP_FIX  = 5'b00100,
      OP_COMP = 5'b01000,
      OP_TOT  = 5'b10000
   } cfl_op_type;

   typedef struct packed {
      logic          issue;
      logic          wb;
      cfl_phase_type phase;
      cfl_op_type    op;
      logic          commit;
      logic          keep;
   } cfl_ctrl_type;

   function automatic logic is_finite(input logic [DATA_W-1:0] x);
      return x[62:52] != EXP_ALL_ONES;
   endfunction

   function automatic logic [DATA_W-1:0] negate(input logic [DATA_W-1:0] x);
      return {~x[63], x[62:0]};
   endfunction

endpackage

// ===== hw/rtl/compensated_fourvector_ledger_top.sv =====
// results leave in lane order, one result per cycle while rsp_ready is high
// work per request: 25 dependent additions per lane through the lane's two-stage adder,
//    each issued and then written back, between a start step and a commit step
// one request may wait in the input register; the commit stalls while results drain
// reset: synchronous active high; all sums and compensation terms return to +0
// uses cfl_pkg, cfl_lane
module compensated_fourvector_ledger_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cfl_pkg::DATA_W-1:0]    req_boundary_lane0,
   input  logic [cfl_pkg::DATA_W-1:0]    req_boundary_lane1,
   input  logic [cfl_pkg::DATA_W-1:0]    req_boundary_lane2,
   input  logic [cfl_pkg::DATA_W-1:0]    req_boundary_lane3,
   input  logic [cfl_pkg::DATA_W-1:0]    req_geometric_lane0,
   input  logic [cfl_pkg::DATA_W-1:0]    req_geometric_lane1,
   input  logic [cfl_pkg::DATA_W-1:0]    req_geometric_lane2,
   input  logic [cfl_pkg::DATA_W-1:0]    req_geometric_lane3,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_lane_index,
   output logic                          rsp_accepted,
   output logic [cfl_pkg::DATA_W-1:0]    rsp_boundary_total,
   output logic [cfl_pkg::DATA_W-1:0]    rsp_geometric_total,
   output logic [cfl_pkg::DATA_W-1:0]    rsp_balance_value,
   output logic                          rsp_last_lane
);
   import cfl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   cfl_phase_type phase_ff, phase_in;
   cfl_op_type    op_ff, op_in;
   logic          half_ff, half_in;

   // input register holds one waiting request
   logic                  hold_v_ff, hold_v_in;
   logic [DATA_W-1:0]     hold_b_ff [LANES];
   logic [DATA_W-1:0]     hold_g_ff [LANES];
   logic [DATA_W-1:0]     act_b_ff [LANES];
   logic [DATA_W-1:0]     act_g_ff [LANES];
   logic [DATA_W-1:0]     req_b [LANES];
   logic [DATA_W-1:0]     req_g [LANES];

   // result drain
   logic                  out_busy_ff, out_busy_in;
   logic [IDX_W-1:0]      out_idx_ff, out_idx_in;
   logic                  out_ok_ff, out_ok_in;

   logic                  req_acc, rsp_acc, start, last_step, commit, all_ok;
   logic [LANES-1:0]      lane_ok;
   logic [DATA_W-1:0]     lane_btot [LANES];
   logic [DATA_W-1:0]     lane_gtot [LANES];
   logic [DATA_W-1:0]     lane_bal [LANES];
   cfl_ctrl_type          ctrl;

   assign req_b[0] = req_boundary_lane0;
   assign req_b[1] = req_boundary_lane1;
   assign req_b[2] = req_boundary_lane2;
   assign req_b[3] = req_boundary_lane3;
   assign req_g[0] = req_geometric_lane0;
   assign req_g[1] = req_geometric_lane1;
   assign req_g[2] = req_geometric_lane2;
   assign req_g[3] = req_geometric_lane3;

   assign req_ready = !hold_v_ff;
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign start     = (state_ff == ST_IDLE) && hold_v_ff;
   assign last_step = (state_ff == ST_RUN) && half_ff && (phase_ff == PH_BAL2)
                      && (op_ff == OP_TOT);
   // commit in the hold state that follows the last write back, so the lane fail flags and
   // balances are settled, and only once the previous request's results have left
   assign commit    = (state_ff == ST_HOLD) && !out_busy_ff;

   // merge: the request is kept only if every lane passed
   assign all_ok    = &lane_ok;

   always_comb begin
      ctrl.issue  = (state_ff == ST_RUN) && !half_ff;
      ctrl.wb     = (state_ff == ST_RUN) && half_ff;
      ctrl.phase  = phase_ff;
      ctrl.op     = op_ff;
      ctrl.commit = commit;
      ctrl.keep   = all_ok;
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      cfl_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .in_b     (act_b_ff[l]),
         .in_g     (act_g_ff[l]),
         .lane_ok  (lane_ok[l]),
         .rep_btot (lane_btot[l]),
         .rep_gtot (lane_gtot[l]),
         .rep_bal  (lane_bal[l])
      );
   end

   // sequencer: five additions per phase, five phases, issue then write back
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      op_in    = op_ff;
      half_in  = half_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               phase_in = PH_BACC;
               op_in    = OP_SUM;
               half_in  = 1'b0;
            end
         end
         ST_RUN: begin
            half_in = !half_ff;
            if (half_ff) begin
               unique case (op_ff)
                  OP_SUM:  op_in = OP_DIFF;
                  OP_DIFF: op_in = OP_FIX;
                  OP_FIX:  op_in = OP_COMP;
                  OP_COMP: op_in = OP_TOT;
                  OP_TOT:  op_in = OP_SUM;
                  default: op_in = OP_SUM;
               endcase
               if (op_ff == OP_TOT) begin
                  unique case (phase_ff)
                     PH_BACC: phase_in = PH_GACC;
                     PH_GACC: phase_in = PH_BAL0;
                     PH_BAL0: phase_in = PH_BAL1;
                     PH_BAL1: phase_in = PH_BAL2;
                     PH_BAL2: phase_in = PH_BACC;
                     default: phase_in = PH_BACC;
                  endcase
               end
            end
            if (last_step) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hold_v_in = hold_v_ff;
      if (start) hold_v_in = 1'b0;
      if (req_acc) hold_v_in = 1'b1;

      out_busy_in = out_busy_ff;
      out_idx_in  = out_idx_ff;
      out_ok_in   = out_ok_ff;
      if (commit) begin
         out_busy_in = 1'b1;
         out_idx_in  = '0;
         out_ok_in   = all_ok;
      end else if (rsp_acc) begin
         out_idx_in = out_idx_ff + 1'b1;
         if (out_idx_ff == IDX_W'(LANES - 1)) out_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_BACC;
         op_ff       <= OP_SUM;
         half_ff     <= 1'b0;
         hold_v_ff   <= 1'b0;
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
         out_ok_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         op_ff       <= op_in;
         half_ff     <= half_in;
         hold_v_ff   <= hold_v_in;
         out_busy_ff <= out_busy_in;
         out_idx_ff  <= out_idx_in;
         out_ok_ff   <= out_ok_in;
      end
   end

   // request payload: waiting slot and the one being worked on
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (req_acc) begin
            hold_b_ff[l] <= req_b[l];
            hold_g_ff[l] <= req_g[l];
         end
         if (start) begin
            act_b_ff[l] <= hold_b_ff[l];
            act_g_ff[l] <= hold_g_ff[l];
         end
      end
   end

   // results read the committed lane totals in lane order
   assign rsp_valid           = out_busy_ff;
   assign rsp_lane_index      = 2'(out_idx_ff);
   assign rsp_accepted        = out_ok_ff;
   assign rsp_boundary_total  = lane_btot[out_idx_ff];
   assign rsp_geometric_total = lane_gtot[out_idx_ff];
   assign rsp_balance_value   = lane_bal[out_idx_ff];
   assign rsp_last_lane       = out_idx_ff == IDX_W'(LANES - 1);

endmodule

// ===== hw/rtl/cfl_fadd.sv =====
// two-stage binary64 adder, round to nearest even, subnormals kept
// stage one aligns and adds, stage two normalizes and rounds; uses cfl_pkg
module cfl_fadd (
   input  logic                          clock,
   input  logic                          load,
   input  logic [cfl_pkg::DATA_W-1:0]    a,
   input  logic [cfl_pkg::DATA_W-1:0]    b,
   output logic [cfl_pkg::DATA_W-1:0]    y
);
   import cfl_pkg::*;

   function automatic logic [5:0] lead_zeros(input logic [55:0] v);
      logic [5:0] n;
      n = 6'd56;
      for (int i = 0; i < 56; i++) begin
         if (v[i]) n = 6'(55 - i);
      end
      return n;
   endfunction

   logic              sign_ff, sign_in;
   logic [10:0]       exp_ff, exp_in;
   logic [56:0]       sum_ff, sum_in;
   logic              sub_ff, sub_in;
   logic              spec_ff, spec_in;
   logic [DATA_W-1:0] specv_ff, specv_in;

   // stage one
   logic              a_big;
   logic [63:0]       x, w;
   logic [10:0]       ex, ew, ex_e, ew_e, align_sh;
   logic [52:0]       mx, mw;
   logic [111:0]      wide;
   logic [55:0]       aligned;

   always_comb begin
      a_big    = a[62:0] >= b[62:0];
      x        = a_big ? a : b;
      w        = a_big ? b : a;
      ex       = x[62:52];
      ew       = w[62:52];
      ex_e     = (ex == 11'd0) ? 11'd1 : ex;
      ew_e     = (ew == 11'd0) ? 11'd1 : ew;
      mx       = {ex != 11'd0, x[51:0]};
      mw       = {ew != 11'd0, w[51:0]};
      align_sh = ex_e - ew_e;
      wide     = {mw, 3'b000, 56'd0} >> align_sh;
      if (align_sh >= 11'd56) begin
         aligned = {55'd0, |mw};
      end else begin
         aligned = {wide[111:57], wide[56] | (|wide[55:0])};
      end
      sub_in  = x[63] ^ w[63];
      sign_in = x[63];
      exp_in  = ex_e;
      if (sub_in) begin
         sum_in = {1'b0, mx, 3'b000} - {1'b0, aligned};
      end else begin
         sum_in = {1'b0, mx, 3'b000} + {1'b0, aligned};
      end
      spec_in = ex == EXP_ALL_ONES;
      if (x[51:0] != 52'd0) begin
         specv_in = CANON_NAN;
      end else if (ew == EXP_ALL_ONES && sub_in) begin
         specv_in = CANON_NAN;
      end else begin
         specv_in = x;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sign_ff  <= sign_in;
         exp_ff   <= exp_in;
         sum_ff   <= sum_in;
         sub_ff   <= sub_in;
         spec_ff  <= spec_in;
         specv_ff <= specv_in;
      end
   end

   // stage two
   logic [5:0]  lz;
   logic [10:0] lim, shift;
   logic [55:0] nrm;
   logic [11:0] e;
   logic [62:0] packed_v, rounded;
   logic        inc, sgn;

   always_comb begin
      lz    = lead_zeros(sum_ff[55:0]);
      lim   = exp_ff - 11'd1;
      shift = ({5'd0, lz} < lim) ? {5'd0, lz} : lim;
      if (sum_ff[56]) begin
         nrm = {sum_ff[56:2], sum_ff[1] | sum_ff[0]};
         e   = {1'b0, exp_ff} + 12'd1;
      end else begin
         nrm = sum_ff[55:0] << shift[5:0];
         e   = {1'b0, exp_ff} - {1'b0, shift};
      end
      packed_v = {nrm[55] ? e[10:0] : 11'd0, nrm[54:3]};
      inc      = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
      rounded  = packed_v + {62'd0, inc};
      sgn      = (sum_ff == 57'd0 && sub_ff) ? 1'b0 : sign_ff;
      if (spec_ff) begin
         y = specv_ff;
      end else if (e >= 12'd2047) begin
         y = {sgn, EXP_ALL_ONES, 52'd0};
      end else begin
         y = {sgn, rounded};
      end
   end

endmodule

// ===== hw/rtl/cfl_lane.sv =====
// one ledger lane: boundary and geometric sums with compensation terms
// trial run of two compensated additions and the balance; uses cfl_pkg, cfl_fadd
module cfl_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  cfl_pkg::cfl_ctrl_type         ctrl,
   input  logic [cfl_pkg::DATA_W-1:0]    in_b,
   input  logic [cfl_pkg::DATA_W-1:0]    in_g,
   output logic                          lane_ok,
   output logic [cfl_pkg::DATA_W-1:0]    rep_btot,
   output logic [cfl_pkg::DATA_W-1:0]    rep_gtot,
   output logic [cfl_pkg::DATA_W-1:0]    rep_bal
);
   import cfl_pkg::*;

   logic [DATA_W-1:0] bs_ff, bc_ff, gs_ff, gc_ff;
   logic [DATA_W-1:0] bs_in, bc_in, gs_in, gc_in;
   logic [DATA_W-1:0] rb_ff, rg_ff, rl_ff, rb_in, rg_in, rl_in;
   logic [DATA_W-1:0] ws_ff, wc_ff, vv_ff, n_ff, t_ff;
   logic [DATA_W-1:0] ws_in, wc_in, vv_in, n_in, t_in;
   logic [DATA_W-1:0] bn_ff, bcn_ff, gn_ff, gcn_ff, btot_ff, gtot_ff, bal_ff;
   logic [DATA_W-1:0] bn_in, bcn_in, gn_in, gcn_in, btot_in, gtot_in, bal_in;
   logic              sel_ff, sel_in, fail_ff, fail_in;

   logic [DATA_W-1:0] s_src, c_src, v_src, op_a, op_b, x;

   cfl_fadd u_fadd (
      .clock (clock),
      .load  (ctrl.issue),
      .a     (op_a),
      .b     (op_b),
      .y     (x)
   );

   always_comb begin
      unique case (ctrl.phase)
         PH_BACC: begin s_src = bs_ff; c_src = bc_ff;    v_src = in_b;          end
         PH_GACC: begin s_src = gs_ff; c_src = gc_ff;    v_src = in_g;          end
         PH_BAL0: begin s_src = bn_ff; c_src = POS_ZERO; v_src = negate(gn_ff); end
         PH_BAL1: begin s_src = ws_ff; c_src = wc_ff;    v_src = bcn_ff;        end
         PH_BAL2: begin s_src = ws_ff; c_src = wc_ff;    v_src = negate(gcn_ff); end
         default: begin s_src = ws_ff; c_src = wc_ff;    v_src = vv_ff;         end
      endcase
      unique case (ctrl.op)
         OP_SUM:  begin op_a = s_src;                   op_b = v_src;         end
         OP_DIFF: begin op_a = sel_ff ? ws_ff : vv_ff;  op_b = negate(n_ff);  end
         OP_FIX:  begin op_a = t_ff;                    op_b = sel_ff ? vv_ff : ws_ff; end
         OP_COMP: begin op_a = wc_ff;                   op_b = t_ff;          end
         OP_TOT:  begin op_a = ws_ff;                   op_b = wc_ff;         end
         default: begin op_a = ws_ff;                   op_b = wc_ff;         end
      endcase
   end

   always_comb begin
      bs_in = bs_ff;  bc_in = bc_ff;  gs_in = gs_ff;  gc_in = gc_ff;
      rb_in = rb_ff;  rg_in = rg_ff;  rl_in = rl_ff;
      ws_in = ws_ff;  wc_in = wc_ff;  vv_in = vv_ff;  n_in = n_ff;  t_in = t_ff;
      bn_in = bn_ff;  bcn_in = bcn_ff; gn_in = gn_ff; gcn_in = gcn_ff;
      btot_in = btot_ff; gtot_in = gtot_ff; bal_in = bal_ff;
      sel_in = sel_ff; fail_in = fail_ff;

      if (ctrl.issue && ctrl.op == OP_SUM) begin
         ws_in  = s_src;
         wc_in  = c_src;
         vv_in  = v_src;
         sel_in = s_src[62:0] >= v_src[62:0];
         if (ctrl.phase == PH_BACC) fail_in = 1'b0;
      end

      if (ctrl.wb) begin
         unique case (ctrl.op)
            OP_SUM: begin
               n_in = x;
               if (!is_finite(vv_ff) || !is_finite(x)) fail_in = 1'b1;
            end
            OP_DIFF, OP_FIX: t_in = x;
            OP_COMP: begin
               wc_in = x;
               ws_in = n_ff;
               if (!is_finite(x)) fail_in = 1'b1;
            end
            OP_TOT: begin
               if (!is_finite(x)) fail_in = 1'b1;
               if (ctrl.phase == PH_BACC) begin
                  bn_in = ws_ff; bcn_in = wc_ff; btot_in = x;
               end
               if (ctrl.phase == PH_GACC) begin
                  gn_in = ws_ff; gcn_in = wc_ff; gtot_in = x;
               end
               if (ctrl.phase == PH_BAL2) bal_in = x;
            end
            default: t_in = t_ff;
         endcase
      end

      // whole item passed in every lane
      if (ctrl.commit && ctrl.keep) begin
         bs_in = bn_ff;   bc_in = bcn_ff;  gs_in = gn_ff;  gc_in = gcn_ff;
         rb_in = btot_ff; rg_in = gtot_ff; rl_in = bal_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff   <= POS_ZERO;
         bc_ff   <= POS_ZERO;
         gs_ff   <= POS_ZERO;
         gc_ff   <= POS_ZERO;
         rb_ff   <= POS_ZERO;
         rg_ff   <= POS_ZERO;
         rl_ff   <= POS_ZERO;
         fail_ff <= 1'b0;
      end else begin
         bs_ff   <= bs_in;
         bc_ff   <= bc_in;
         gs_ff   <= gs_in;
         gc_ff   <= gc_in;
         rb_ff   <= rb_in;
         rg_ff   <= rg_in;
         rl_ff   <= rl_in;
         fail_ff <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      ws_ff   <= ws_in;
      wc_ff   <= wc_in;
      vv_ff   <= vv_in;
      n_ff    <= n_in;
      t_ff    <= t_in;
      sel_ff  <= sel_in;
      bn_ff   <= bn_in;
      bcn_ff  <= bcn_in;
      gn_ff   <= gn_in;
      gcn_ff  <= gcn_in;
      btot_ff <= btot_in;
      gtot_ff <= gtot_in;
      bal_ff  <= bal_in;
   end

   assign lane_ok  = !fail_ff;
   assign rep_btot = rb_ff;
   assign rep_gtot = rg_ff;
   assign rep_bal  = rl_ff;

endmodule

// ===== hw/rtl/cfl_checker.sv =====
// port-level checks on the result channel of the ledger top level
// uses cfl_pkg; bound to compensated_fourvector_ledger_top
module cfl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_lane_index,
   input logic                          rsp_accepted,
   input logic [cfl_pkg::DATA_W-1:0]    rsp_boundary_total,
   input logic                          rsp_last_lane
);
   import cfl_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_last_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_lane == (rsp_lane_index == 2'(LANES - 1))))
      else $error("last lane flag disagrees with lane index");

   a_lane_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_lane |=>
         rsp_valid && rsp_lane_index == $past(rsp_lane_index) + 2'd1)
      else $error("results of a request not in lane order");

   a_accept_flag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_lane |=> rsp_accepted == $past(rsp_accepted))
      else $error("accepted flag changed within a request");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_boundary_total))
      else $error("stalled result changed");

endmodule

bind compensated_fourvector_ledger_top cfl_checker u_cfl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_lane_index     (rsp_lane_index),
   .rsp_accepted       (rsp_accepted),
   .rsp_boundary_total (rsp_boundary_total),
   .rsp_last_lane      (rsp_last_lane)
);

// ===== test/tb_compensated_fourvector_ledger_top.sv =====
// self-checking testbench for compensated_fourvector_ledger_top: a queue-fed driver and a
// result monitor, with a double-precision predictor of the two compensated four-lane banks
// depends on cfl_pkg and the compensated_fourvector_ledger_top rtl
module tb_compensated_fourvector_ledger_top;
   import cfl_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] bnd [LANES];
      logic [DATA_W-1:0] geo [LANES];
   } ledger_request_type;

   typedef struct {
      logic [1:0]        lane;
      logic              accepted;
      logic [DATA_W-1:0] bnd_total;
      logic [DATA_W-1:0] geo_total;
      logic [DATA_W-1:0] balance;
      logic              last;
   } lane_report_type;

   localparam int N_RANDOM = 158;
   localparam int SETTLE_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_lane_index;
   logic rsp_accepted;
   logic [DATA_W-1:0] rsp_boundary_total, rsp_geometric_total, rsp_balance_value;
   logic rsp_last_lane;
   logic [DATA_W-1:0] drv_bnd [LANES];
   logic [DATA_W-1:0] drv_geo [LANES];

   // requests waiting to be driven, and lane reports waiting to arrive
   ledger_request_type pending_q[$];
   lane_report_type report_q[$];
   ledger_request_type cur_req;

   // predictor state: running sums and compensation terms of both banks
   real bnd_sum [LANES];
   real bnd_comp [LANES];
   real geo_sum [LANES];
   real geo_comp [LANES];

   int n_total = 0;          // requests placed in the pending queue
   int n_sent = 0;           // requests accepted by the block
   int n_rejected = 0;       // predicted rejections
   int n_reports = 0;
   int n_mismatch = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 52;
   logic req_fire = 1'b0;
   bit filled = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   compensated_fourvector_ledger_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_boundary_lane0  (drv_bnd[0]),
      .req_boundary_lane1  (drv_bnd[1]),
      .req_boundary_lane2  (drv_bnd[2]),
      .req_boundary_lane3  (drv_bnd[3]),
      .req_geometric_lane0 (drv_geo[0]),
      .req_geometric_lane1 (drv_geo[1]),
      .req_geometric_lane2 (drv_geo[2]),
      .req_geometric_lane3 (drv_geo[3]),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_lane_index      (rsp_lane_index),
      .rsp_accepted        (rsp_accepted),
      .rsp_boundary_total  (rsp_boundary_total),
      .rsp_geometric_total (rsp_geometric_total),
      .rsp_balance_value   (rsp_balance_value),
      .rsp_last_lane       (rsp_last_lane)
   );

   // finiteness and magnitude are judged on the bit pattern, as the block does
   function automatic bit dbl_finite(input real x);
      logic [63:0] b;
      b = $realtobits(x);
      return b[62:52] != EXP_ALL_ONES;
   endfunction

   function automatic real dbl_neg(input real x);
      logic [63:0] b;
      b = $realtobits(x);
      return $bitstoreal({~b[63], b[62:0]});
   endfunction

   function automatic real dbl_abs(input real x);
      logic [63:0] b;
      b = $realtobits(x);
      return $bitstoreal({1'b0, b[62:0]});
   endfunction

   // one neumaier step: fold v into (s, c); 0 when anything leaves the finite range
   function automatic bit neumaier_add(input real v, inout real s, inout real c);
      real n;
      if (!dbl_finite(v)) return 1'b0;
      n = s + v;
      if (!dbl_finite(n)) return 1'b0;
      if (dbl_abs(s) >= dbl_abs(v))
         c = c + ((s - n) + v);
      else
         c = c + ((v - n) + s);
      s = n;
      return dbl_finite(c) && dbl_finite(s + c);
   endfunction

   // compensated boundary minus geometric of one lane
   function automatic bit lane_difference(input real bs, input real bc, input real gs,
                                          input real gc, output real diff);
      real s;
      real c;
      bit ok;
      s = bs;
      c = 0.0;
      ok = neumaier_add(dbl_neg(gs), s, c);
      if (ok) ok = neumaier_add(bc, s, c);
      if (ok) ok = neumaier_add(dbl_neg(gc), s, c);
      diff = s + c;
      return ok;
   endfunction

   // apply one request to the ledger and queue the four lane reports it yields
   task automatic ledger_update(input ledger_request_type r);
      real ws [LANES];
      real wc [LANES];
      real xs [LANES];
      real xc [LANES];
      real diff;
      bit ok;
      bit lane_ok;
      lane_report_type rep;
      ok = 1'b1;
      for (int d = 0; d < LANES; d++) begin
         ws[d] = bnd_sum[d];
         wc[d] = bnd_comp[d];
         xs[d] = geo_sum[d];
         xc[d] = geo_comp[d];
      end
      for (int d = 0; d < LANES; d++) begin
         if (ok) ok = neumaier_add($bitstoreal(r.bnd[d]), ws[d], wc[d]);
         if (ok) ok = neumaier_add($bitstoreal(r.geo[d]), xs[d], xc[d]);
      end
      for (int d = 0; d < LANES; d++) begin
         if (ok) begin
            ok = lane_difference(ws[d], wc[d], xs[d], xc[d], diff);
            if (ok) ok = dbl_finite(diff);
         end
      end
      if (ok) begin
         for (int d = 0; d < LANES; d++) begin
            bnd_sum[d] = ws[d];
            bnd_comp[d] = wc[d];
            geo_sum[d] = xs[d];
            geo_comp[d] = xc[d];
         end
      end else begin
         n_rejected++;
      end
      for (int d = 0; d < LANES; d++) begin
         lane_ok = lane_difference(bnd_sum[d], bnd_comp[d], geo_sum[d], geo_comp[d], diff);
         rep.lane = d[1:0];
         rep.accepted = ok;
         rep.bnd_total = $realtobits(bnd_sum[d] + bnd_comp[d]);
         rep.geo_total = $realtobits(geo_sum[d] + geo_comp[d]);
         rep.balance = lane_ok ? $realtobits(diff) : CANON_NAN;
         rep.last = (d == LANES - 1);
         report_q.push_back(rep);
      end
   endtask

   // random double with a bias toward moderate values that keep the ledger busy
   function automatic logic [63:0] random_double();
      logic [63:0] raw;
      int pick;
      raw = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 62) return {raw[63], 11'(1023 + $urandom_range(0, 80) - 40), raw[51:0]};
      if (pick < 74) return $realtobits(real'(int'($urandom_range(0, 2000)) - 1000));
      if (pick < 84) return raw;
      if (pick < 89) return {raw[63], 11'h7FE - 11'($urandom_range(0, 1)), raw[51:0]};
      if (pick < 92) return {raw[63], EXP_ALL_ONES, raw[51:0]};  // inf or nan
      if (pick < 96) return {raw[63], 11'h000, raw[51:0]};       // zero or subnormal
      return {raw[63], 11'(1023 + $urandom_range(0, 6) - 3), 52'h0};
   endfunction

   task automatic queue_request(input logic [63:0] b0, b1, b2, b3, g0, g1, g2, g3);
      ledger_request_type r;
      r.bnd[0] = b0; r.bnd[1] = b1; r.bnd[2] = b2; r.bnd[3] = b3;
      r.geo[0] = g0; r.geo[1] = g1; r.geo[2] = g2; r.geo[3] = g3;
      pending_q.push_back(r);
      n_total++;
   endtask

   // stimulus: directed corners first, then random requests
   initial begin
      logic [63:0] b [LANES];
      logic [63:0] g [LANES];
      logic [63:0] one_bits, big_bits, max_bits;
      one_bits = $realtobits(1.0);
      big_bits = $realtobits(1.0e16);
      max_bits = 64'h7FEF_FFFF_FFFF_FFFF;
      // all zeros, then negative zeros
      queue_request(0, 0, 0, 0, 0, 0, 0, 0);
      queue_request({1'b1, 63'h0}, {1'b1, 63'h0}, {1'b1, 63'h0}, {1'b1, 63'h0},
                    {1'b1, 63'h0}, {1'b1, 63'h0}, {1'b1, 63'h0}, {1'b1, 63'h0});
      // cancellation that only the compensation term survives
      queue_request(big_bits, one_bits, 0, 0, one_bits, big_bits, 0, 0);
      queue_request(one_bits, big_bits, 0, 0, big_bits, one_bits, 0, 0);
      queue_request(big_bits ^ 64'h8000_0000_0000_0000, 0, 0, 0,
                    0, big_bits ^ 64'h8000_0000_0000_0000, 0, 0);
      // smallest subnormal and largest finite magnitude
      queue_request(64'h1, 64'h8000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 0,
                    64'h1, 0, 0, 64'h800F_FFFF_FFFF_FFFF);
      queue_request(max_bits, 0, 0, 0, 0, 0, 0, 0);
      // overflow in the boundary sum rejects the whole request
      queue_request(max_bits, 0, 0, 0, 0, 0, 0, 0);
      // balance overflow: huge boundary against huge negative geometric
      queue_request(0, max_bits, 0, 0, 0, max_bits | 64'h8000_0000_0000_0000, 0, 0);
      queue_request(max_bits | 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 0, 0);
      // non-finite increments in both banks and in every lane position
      queue_request(64'h7FF0_0000_0000_0000, 0, 0, 0, 0, 0, 0, 0);
      queue_request(0, 0, 0, 0, 0, 0, 0, 64'hFFF0_0000_0000_0000);
      queue_request(0, 0, CANON_NAN, 0, 0, 0, 0, 0);
      queue_request(one_bits, one_bits, one_bits, one_bits,
                    0, 64'hFFF8_0000_0000_0001, 0, 0);
      queue_request(64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
      // ordinary values in every lane
      queue_request(one_bits, $realtobits(-2.5), $realtobits(3.0e-300), $realtobits(7.0e300),
                    $realtobits(0.1), $realtobits(0.2), $realtobits(-3.0e-300),
                    $realtobits(-7.0e300));
      for (int k = 0; k < N_RANDOM; k++) begin
         for (int d = 0; d < LANES; d++) begin
            b[d] = random_double();
            g[d] = random_double();
         end
         queue_request(b[0], b[1], b[2], b[3], g[0], g[1], g[2], g[3]);
      end
      filled = 1'b1;
   end

   // acceptance: the predictor runs at the edge where the request is taken
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      if (req_valid && req_ready) begin
         ledger_update(cur_req);
         n_sent++;
      end
   end

   // driver: new payload or a gap at the falling edge
   always @(negedge clock) begin
      // three idling phases keyed on progress through the request list
      if (n_sent < n_total / 3) begin
         send_idle_pct = 37;
         recv_idle_pct = 52;
      end else if (n_sent < 2 * n_total / 3) begin
         send_idle_pct = 52;
         recv_idle_pct = 37;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            cur_req = pending_q.pop_front();
            for (int d = 0; d < LANES; d++) begin
               drv_bnd[d] <= cur_req.bnd[d];
               drv_geo[d] <= cur_req.geo[d];
            end
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      for (int d = 0; d < LANES; d++) begin
         drv_bnd[d] = '0;
         drv_geo[d] = '0;
         bnd_sum[d] = 0.0;
         bnd_comp[d] = 0.0;
         geo_sum[d] = 0.0;
         geo_comp[d] = 0.0;
      end
   end

   // monitor: every lane report against the oldest prediction
   always @(posedge clock) begin
      lane_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_reports++;
         if (report_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("unexpected lane report: lane %0d balance %h",
                        rsp_lane_index, rsp_balance_value);
         end else begin
            want = report_q.pop_front();
            if (rsp_lane_index !== want.lane || rsp_accepted !== want.accepted ||
                rsp_boundary_total !== want.bnd_total ||
                rsp_geometric_total !== want.geo_total ||
                rsp_balance_value !== want.balance || rsp_last_lane !== want.last) begin
               n_mismatch++;
               if (n_mismatch <= 10) begin
                  $display("mismatch on report %0d: expected lane %0d acc %b bnd %h geo %h",
                           n_reports, want.lane, want.accepted, want.bnd_total,
                           want.geo_total);
                  $display("   bal %h last %b; got lane %0d acc %b bnd %h geo %h bal %h last %b",
                           want.balance, want.last, rsp_lane_index, rsp_accepted,
                           rsp_boundary_total, rsp_geometric_total, rsp_balance_value,
                           rsp_last_lane);
               end
            end
         end
      end
   end

   // reset, then wait for all requests and reports to drain
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (filled);
      wait (pending_q.size() == 0 && !req_valid);
      wait (report_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests (%0d predicted rejections), %0d lane reports checked",
               n_sent, n_rejected, n_reports);
      if (n_mismatch == 0 && report_q.size() == 0) begin
         $display("compensated_fourvector_ledger_top verification clean");
      end else begin
         $display("%0d mismatches, %0d reports outstanding", n_mismatch, report_q.size());
         $display("compensated_fourvector_ledger_top verification failed");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #4000000;
      $display("timeout with %0d requests sent and %0d reports outstanding",
               n_sent, report_q.size());
      $display("compensated_fourvector_ledger_top verification failed");
      $finish;
   end

endmodule
